/* design/odtm_pkg.sv */
package odtm_pkg;

    localparam int DATA_W    = 16;
    localparam int SIZE_W    = 4;
    localparam int ENTRY_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_OUTPUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_OUTPUT  = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd4;
    localparam logic [DATA_W-1:0] HIGH_RESET = 16'd255;
    localparam logic [DATA_W-1:0] LOW_RESET  = 16'd0;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Reciprocal of each side length, scaled by 2**RECIP_SHIFT and rounded down.
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_W     = 18;
    localparam logic [RECIP_W-1:0] RECIP [0:8] = '{
        18'd131072, 18'd131072, 18'd65536, 18'd43690, 18'd32768,
        18'd26214,  18'd21845,  18'd18724, 18'd16384
    };

    typedef struct packed {
        logic [SIZE_W-1:0] side;
        logic [DATA_W-1:0] high;
        logic [DATA_W-1:0] low;
    } t_cfg;

endpackage

/* design/odtm_front.sv */
module odtm_front #(
    parameter int MAX_DIM = 8,
    parameter int ENT_W   = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  odtm_pkg::t_cfg            i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_command,
    input  logic [odtm_pkg::DATA_W-1:0] i_row,
    input  logic [odtm_pkg::DATA_W-1:0] i_col,
    input  logic [odtm_pkg::DATA_W-1:0] i_sample,
    input  logic [odtm_pkg::Q_CNT_W-1:0] i_q_count,
    output logic                      o_push,
    output logic [ENT_W-1:0]          o_entry
);
    import odtm_pkg::*;

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int PROD_W = DATA_W + RECIP_W;

    logic              r_valid;
    logic              r_pixel;
    logic [DATA_W-1:0] r_row;
    logic [DATA_W-1:0] r_col;
    logic [DATA_W-1:0] r_qrow;
    logic [DATA_W-1:0] r_qcol;
    logic [DATA_W-1:0] r_sample;

    logic              w_accept;
    logic [RECIP_W-1:0] w_recip;
    logic [PROD_W-1:0] w_prow;
    logic [PROD_W-1:0] w_pcol;
    logic [DATA_W:0]   w_rrow;
    logic [DATA_W:0]   w_rcol;
    logic [DATA_W:0]   w_rrow_fix;
    logic [DATA_W:0]   w_rcol_fix;
    logic [IDX_W-1:0]  w_row_idx;
    logic [IDX_W-1:0]  w_col_idx;
    logic              w_in_range;
    logic [AW-1:0]     w_addr;

    assign o_ready  = (i_q_count + Q_CNT_W'(r_valid)) < Q_CNT_W'(Q_DEPTH);
    assign w_accept = i_valid && o_ready;

    assign w_recip = RECIP[i_cfg.side];
    assign w_prow  = PROD_W'(i_row) * PROD_W'(w_recip);
    assign w_pcol  = PROD_W'(i_col) * PROD_W'(w_recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pixel  <= (i_command == CMD_PIXEL);
            r_row    <= i_row;
            r_col    <= i_col;
            r_sample <= i_sample;
            r_qrow   <= w_prow[RECIP_SHIFT +: DATA_W];
            r_qcol   <= w_pcol[RECIP_SHIFT +: DATA_W];
        end
    end

    // The estimated quotient is exact or one short, so one correction finishes the remainder.
    always_comb begin
        w_rrow = (DATA_W + 1)'(r_row) - (DATA_W + 1)'(r_qrow * i_cfg.side);
        w_rcol = (DATA_W + 1)'(r_col) - (DATA_W + 1)'(r_qcol * i_cfg.side);
        w_rrow_fix = (w_rrow >= (DATA_W + 1)'(i_cfg.side))
                   ? w_rrow - (DATA_W + 1)'(i_cfg.side) : w_rrow;
        w_rcol_fix = (w_rcol >= (DATA_W + 1)'(i_cfg.side))
                   ? w_rcol - (DATA_W + 1)'(i_cfg.side) : w_rcol;
        w_in_range = (r_row < DATA_W'(MAX_DIM)) && (r_col < DATA_W'(MAX_DIM));
        if (r_pixel) begin
            w_row_idx = w_rrow_fix[IDX_W-1:0];
            w_col_idx = w_rcol_fix[IDX_W-1:0];
        end else begin
            w_row_idx = r_row[IDX_W-1:0];
            w_col_idx = r_col[IDX_W-1:0];
        end
        w_addr = AW'(AW'(w_row_idx) * AW'(MAX_DIM)) + AW'(w_col_idx);
    end

    assign o_push  = r_valid;
    assign o_entry = {r_pixel, w_in_range, w_addr, r_sample};

endmodule

/* design/odtm_queue.sv */
module odtm_queue #(
    parameter int WIDTH = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_entry,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_head,
    output logic                         o_not_empty,
    output logic [odtm_pkg::Q_CNT_W-1:0] o_count
);
    import odtm_pkg::*;

    logic [WIDTH-1:0]   r_slot [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;
    logic               w_pop;

    assign w_pop       = i_pop && (r_count != '0);
    assign o_head      = r_slot[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_count     = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* design/odtm_back.sv */
module odtm_back #(
    parameter int MAX_DIM = 8,
    parameter int ENT_W   = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  odtm_pkg::t_cfg              i_cfg,
    input  logic [ENT_W-1:0]            i_head,
    input  logic                        i_not_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [odtm_pkg::DATA_W-1:0] o_dithered
);
    import odtm_pkg::*;

    localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int D_W   = 2 * SIZE_W - 1;
    localparam int DV_W  = DATA_W + D_W;
    localparam int HE_W  = DATA_W + ENTRY_W + 1;
    localparam int HD_W  = DATA_W + D_W;
    localparam int CMP_W = DV_W + 3;

    logic [ENTRY_W-1:0] r_mem [0:CELLS-1];

    logic               w_pixel;
    logic               w_in_range;
    logic [AW-1:0]      w_addr;
    logic [DATA_W-1:0]  w_sample;
    logic               w_en1;
    logic               w_en2;
    logic               w_en3;
    logic [2*SIZE_W-1:0] w_side_ext;
    logic [DV_W-1:0]    w_dv;
    logic [HE_W-1:0]    w_he;
    logic [HD_W-1:0]    w_hd;
    logic [CMP_W-1:0]   w_lhs;

    logic [D_W-1:0]     r_d;
    logic [HD_W-1:0]    r_hd;
    logic [CMP_W-1:0]   r_rhs;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic [ENTRY_W-1:0] r_e1;
    logic [DV_W+1:0]    r_dv1;
    logic [DV_W+1:0]    r_dv2;
    logic [HE_W:0]      r_he2;
    logic [DATA_W-1:0]  r_out;

    assign {w_pixel, w_in_range, w_addr, w_sample} = i_head;

    assign w_en3 = !r_v3 || i_ready;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign o_pop = i_not_empty && w_en1;

    assign w_side_ext = (2 * SIZE_W)'(i_cfg.side);
    assign w_hd  = HD_W'(i_cfg.high) * HD_W'(r_d);
    assign w_dv  = DV_W'(r_d) * DV_W'(w_sample);
    assign w_he  = HE_W'(i_cfg.high) * (HE_W'(r_e1) + HE_W'(1));
    assign w_lhs = CMP_W'(r_dv2) + CMP_W'(r_he2);

    always_ff @(posedge i_clk) begin
        r_d   <= D_W'(w_side_ext * w_side_ext);
        r_hd  <= w_hd;
        r_rhs <= CMP_W'({r_hd, 1'b0}) + CMP_W'(r_hd);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !w_pixel && w_in_range) begin
            r_mem[w_addr] <= w_sample[ENTRY_W-1:0];
        end
        if (w_en1) begin
            r_e1  <= r_mem[w_addr];
            r_dv1 <= {w_dv, 2'b00};
        end
        if (w_en2) begin
            r_dv2 <= r_dv1;
            r_he2 <= {w_he, 1'b0};
        end
        if (w_en3) begin
            r_out <= (w_lhs > r_rhs) ? i_cfg.high : i_cfg.low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= o_pop && w_pixel;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_valid    = r_v3;
    assign o_dithered = r_out;

endmodule

/* design/ordered_dither_threshold_matrix.sv */
// Channel    | Handshake             | Payload
// -----------+-----------------------+-------------------------------------
// input      | i_valid / o_ready     | i_command, i_row, i_col, i_sample
// output     | o_valid / i_ready     | o_dithered
// config     | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// One transaction is accepted per cycle while o_ready is high.
// A pixel passes through the modulo stage, the four-entry queue and three back-end stages.
// Loads travel the same queue, so a pixel always sees every earlier load.
// Reset clears the pipeline and queue and restores the register defaults.
// Output stalls back up the queue; input is held off once queue and front stage hold Q_DEPTH.
module ordered_dither_threshold_matrix #(
    parameter int MAX_DIM = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_command,
    input  logic [odtm_pkg::DATA_W-1:0]    i_row,
    input  logic [odtm_pkg::DATA_W-1:0]    i_col,
    input  logic [odtm_pkg::DATA_W-1:0]    i_sample,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [odtm_pkg::DATA_W-1:0]    o_dithered,
    input  logic                           i_cfg_we,
    input  logic [odtm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [odtm_pkg::DATA_W-1:0]    i_cfg_data
);
    import odtm_pkg::*;

    localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int ENT_W = 2 + AW + DATA_W;

    logic [SIZE_W-1:0] r_size;
    logic [DATA_W-1:0] r_high;
    logic [DATA_W-1:0] r_low;
    t_cfg              w_cfg;

    logic               w_push;
    logic [ENT_W-1:0]   w_entry;
    logic               w_pop;
    logic [ENT_W-1:0]   w_head;
    logic               w_not_empty;
    logic [Q_CNT_W-1:0] w_q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
            r_high <= HIGH_RESET;
            r_low  <= LOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MATRIX_SIZE: r_size <= i_cfg_data[SIZE_W-1:0];
                CFG_HIGH_OUTPUT: r_high <= i_cfg_data;
                CFG_LOW_OUTPUT:  r_low  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_size == '0) begin
            w_cfg.side = SIZE_W'(1);
        end else if (r_size > SIZE_W'(MAX_DIM)) begin
            w_cfg.side = SIZE_W'(MAX_DIM);
        end else begin
            w_cfg.side = r_size;
        end
        w_cfg.high = r_high;
        w_cfg.low  = r_low;
    end

    odtm_front #(
        .MAX_DIM (MAX_DIM),
        .ENT_W   (ENT_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .i_row     (i_row),
        .i_col     (i_col),
        .i_sample  (i_sample),
        .i_q_count (w_q_count),
        .o_push    (w_push),
        .o_entry   (w_entry)
    );

    odtm_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_entry     (w_entry),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_not_empty (w_not_empty),
        .o_count     (w_q_count)
    );

    odtm_back #(
        .MAX_DIM (MAX_DIM),
        .ENT_W   (ENT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_head      (w_head),
        .i_not_empty (w_not_empty),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_dithered  (o_dithered)
    );

endmodule

/* tb/tb_ordered_dither_threshold_matrix.sv */
module tb_ordered_dither_threshold_matrix;
    timeunit 1ns;
    timeprecision 1ps;

    import odtm_pkg::*;

    localparam int MAX_DIM = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 110;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic              command;
        logic [DATA_W-1:0] row;
        logic [DATA_W-1:0] col;
        logic [DATA_W-1:0] sample;
    } t_stream_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_command = CMD_LOAD;
    logic [DATA_W-1:0]    i_row = '0;
    logic [DATA_W-1:0]    i_col = '0;
    logic [DATA_W-1:0]    i_sample = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [DATA_W-1:0]    o_dithered;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_MATRIX_SIZE;
    logic [DATA_W-1:0]    i_cfg_data = '0;

    t_stream_item      pending_items[$];
    logic [DATA_W-1:0] expected_levels[$];
    logic [ENTRY_W-1:0] bayer_cells [MAX_DIM*MAX_DIM];
    logic [ENTRY_W-1:0] plan_cells [MAX_DIM*MAX_DIM];
    t_cfg              cur_cfg = '{side: SIZE_RESET, high: HIGH_RESET, low: LOW_RESET};

    t_stream_item      next_item;
    logic [DATA_W-1:0] want_level;
    int unsigned       gap_left = 0;
    int unsigned       stall_left = 0;
    bit                gap_on = 1'b1;
    bit                stall_on = 1'b1;
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;

    ordered_dither_threshold_matrix #(
        .MAX_DIM(MAX_DIM)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_sample   (i_sample),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_dithered (o_dithered),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned side_of(logic [SIZE_W-1:0] raw);
        if (raw == 0) begin
            return 1;
        end
        if (raw > MAX_DIM) begin
            return MAX_DIM;
        end
        return 32'(raw);
    endfunction

    function automatic logic [DATA_W-1:0] dither_level(logic [DATA_W-1:0] row,
                                                       logic [DATA_W-1:0] col,
                                                       logic [DATA_W-1:0] sample);
        longint unsigned side, cells, entry, level, hi, lhs, rhs;
        side = 64'(side_of(cur_cfg.side));
        cells = side * side;
        entry = 64'(bayer_cells[(row % side) * MAX_DIM + (col % side)]);
        level = 64'(sample);
        hi = 64'(cur_cfg.high);
        lhs = 4 * cells * level + 2 * hi * (entry + 1);
        rhs = 3 * hi * cells;
        return (lhs > rhs) ? cur_cfg.high : cur_cfg.low;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic queue_item(logic cmd, logic [DATA_W-1:0] row, logic [DATA_W-1:0] col,
                              logic [DATA_W-1:0] sample);
        pending_items.push_back('{command: cmd, row: row, col: col, sample: sample});
        if (cmd == CMD_LOAD && row < MAX_DIM && col < MAX_DIM) begin
            plan_cells[row * MAX_DIM + col] = sample[ENTRY_W-1:0];
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_MATRIX_SIZE: cur_cfg.side = data[SIZE_W-1:0];
            CFG_HIGH_OUTPUT: cur_cfg.high = data;
            CFG_LOW_OUTPUT:  cur_cfg.low = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [DATA_W-1:0] size_data, logic [DATA_W-1:0] hi,
                                 logic [DATA_W-1:0] lo, bit poke_spare);
        write_reg(CFG_MATRIX_SIZE, size_data);
        write_reg(CFG_HIGH_OUTPUT, hi);
        write_reg(CFG_LOW_OUTPUT, lo);
        if (poke_spare) begin
            write_reg(CFG_SPARE, 16'($urandom));
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || i_valid || expected_levels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random_items(int unsigned count);
        int unsigned side, cells, entry, cut;
        int near;
        logic [DATA_W-1:0] row, col, sample;
        side = side_of(cur_cfg.side);
        cells = side * side;
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) begin
                row = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, MAX_DIM - 1))
                                                   : 16'($urandom);
                col = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, MAX_DIM - 1))
                                                   : 16'($urandom);
                case ($urandom_range(0, 9))
                    0, 1:    sample = 16'($urandom);
                    2, 3, 4: sample = 16'($urandom_range(0, 63));
                    default: sample = 16'($urandom_range(0, cells - 1));
                endcase
                queue_item(CMD_LOAD, row, col, sample);
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    row = 16'($urandom_range(0, 15));
                    col = 16'($urandom_range(0, 15));
                end else begin
                    row = 16'($urandom);
                    col = 16'($urandom);
                end
                entry = 32'(plan_cells[(row % side) * MAX_DIM + (col % side)]);
                case ($urandom_range(0, 9))
                    0: sample = $urandom_range(0, 1) ? '1 : '0;
                    1, 2, 3, 4: begin
                        // Aim at the point where the pixel flips between the two levels.
                        cut = (3 * cells > 2 * (entry + 1)) ?
                              cur_cfg.high * (3 * cells - 2 * (entry + 1)) / (4 * cells) : 0;
                        near = int'(cut) + int'($urandom_range(0, 4)) - 2;
                        if (near < 0) begin
                            near = 0;
                        end
                        if (near > 65535) begin
                            near = 65535;
                        end
                        sample = 16'(near);
                    end
                    default: sample = 16'($urandom);
                endcase
                queue_item(CMD_PIXEL, row, col, sample);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                if (i_command == CMD_LOAD) begin
                    if (i_row < MAX_DIM && i_col < MAX_DIM) begin
                        bayer_cells[i_row * MAX_DIM + i_col] = i_sample[ENTRY_W-1:0];
                    end
                end else begin
                    expected_levels.push_back(dither_level(i_row, i_col, i_sample));
                end
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_command <= next_item.command;
                    i_row <= next_item.row;
                    i_col <= next_item.col;
                    i_sample <= next_item.sample;
                    if (gap_on && $urandom_range(0, 99) < 30) begin
                        gap_left = pick_gap();
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_levels.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no pixel pending", o_dithered));
                end else begin
                    want_level = expected_levels.pop_front();
                    if (o_dithered !== want_level) begin
                        report_mismatch($sformatf("dithered %0d, expected %0d",
                                                  o_dithered, want_level));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (stall_on && $urandom_range(0, 99) < 25) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int unsigned phase_sizes [12];
        logic [DATA_W-1:0] size_data, hi, lo;

        phase_sizes = '{1, 8, 0, 15, 9, 2, 3, 5, 6, 7, 4, 8};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every cell is written before the first pixel so no lookup hits an empty cell.
        for (int r = 0; r < MAX_DIM; r++) begin
            for (int c = 0; c < MAX_DIM; c++) begin
                queue_item(CMD_LOAD, 16'(r), 16'(c), 16'(r * MAX_DIM + c));
            end
        end
        queue_item(CMD_LOAD, 7, 7, 16'hFFC5);
        queue_item(CMD_LOAD, 8, 0, 0);
        queue_item(CMD_LOAD, 0, 8, 0);
        queue_item(CMD_LOAD, 16'hFFFF, 16'hFFFF, 0);
        queue_item(CMD_LOAD, 16'h0008, 16'h0003, 0);
        queue_item(CMD_PIXEL, 0, 0, 0);
        queue_item(CMD_PIXEL, 0, 0, 16'hFFFF);
        queue_item(CMD_PIXEL, 16'hFFFF, 16'hFFFF, 16'h8000);
        queue_item(CMD_PIXEL, 3, 3, 0);
        queue_item(CMD_PIXEL, 1, 2, 103);
        queue_item(CMD_PIXEL, 1, 2, 104);
        queue_item(CMD_PIXEL, 16'h8000, 16'h0001, 16'h7FFF);
        queue_item(CMD_PIXEL, 7, 7, 16'h5555);
        queue_item(CMD_PIXEL, 16'hAAAA, 16'h5555, 16'hAAAA);
        wait_idle();

        for (int p = 0; p < 12; p++) begin
            case (p)
                0: begin
                    hi = 16'hFFFF;
                    lo = 16'h0000;
                end
                1: begin
                    hi = 16'h0001;
                    lo = 16'hFFFF;
                end
                2: begin
                    hi = 16'h0001;
                    lo = 16'h0000;
                end
                3: begin
                    hi = 16'hFFFF;
                    lo = 16'h0001;
                end
                default: begin
                    hi = 16'($urandom_range(1, 65535));
                    lo = 16'($urandom_range(0, 65535));
                end
            endcase
            size_data = (p % 2 == 1) ? 16'($urandom) : '0;
            size_data[SIZE_W-1:0] = SIZE_W'(phase_sizes[p]);
            apply_setting(size_data, hi, lo, p % 4 == 1);
            gap_on = (p % 4 != 3);
            stall_on = (p % 3 != 2) && (p != 3);
            queue_random_items(PHASE_ITEMS);
            wait_idle();
        end

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
